// ===== hw/rtl/mt_pkg.sv =====
// ----------------------------------------------------------------------------
// mt_pkg
// Constants, types and helper functions shared by the MT19937 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mt_pkg;

    // state store geometry
    localparam int unsigned MT_N      = 624;
    localparam int unsigned MT_M      = 397;
    localparam int unsigned ADDR_W    = 10;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PROB_W    = 33;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MT_N - 1);
    localparam logic [ADDR_W-1:0] OFFSET_M   = ADDR_W'(MT_M);
    localparam logic [ADDR_W:0]   N_WIDE     = (ADDR_W + 1)'(MT_N);

    // recurrence and tempering constants
    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MT_MULT     = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_RESET  = 32'd5489;

    // one write request into the state memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } mt_wr_t;

    // twist mixing of word i with word i+1
    function automatic logic [WORD_W-1:0] mt_mix(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] y;
        y = (a & MT_UPPER) | (b & MT_LOWER);
        return (y >> 1) ^ (b[0] ? MT_MATRIX : '0);
    endfunction

    // output tempering
    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mt_ram.sv =====
// ----------------------------------------------------------------------------
// mt_ram
// 624 x 32 state memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mt_ram
    import mt_pkg::*;
(
    input  wire logic              aclk,
    input  wire mt_wr_t            wr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [MT_N];

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mt_seed_fill.sv =====
// ----------------------------------------------------------------------------
// mt_seed_fill
// Fills the state memory from the seed, w[i] = MULT*(w[i-1]^(w[i-1]>>30))+i.
// ----------------------------------------------------------------------------
`default_nettype none

module mt_seed_fill
    import mt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] seed,
    output mt_wr_t                 wr,
    output logic                   done
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_ADD  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] sum;

    assign sum = prod_reg + {{(WORD_W-ADDR_W){1'b0}}, idx_reg};

    // sequencer: seed word on start, then multiply in F_MUL, add and write in F_ADD
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        wr         = '0;
        done       = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (start) begin
                    wr.en      = 1'b1;
                    wr.addr    = '0;
                    wr.data    = seed;
                    prev_next  = seed;
                    idx_next   = ADDR_W'(1);
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                prod_next  = MT_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = F_ADD;
            end
            F_ADD: begin
                wr.en     = 1'b1;
                wr.addr   = idx_reg;
                wr.data   = sum;
                prev_next = sum;
                if (idx_reg == LAST_ADDR) begin
                    done       = 1'b1;
                    state_next = F_IDLE;
                end else begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = F_MUL;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mt19937_generator.sv =====
// ----------------------------------------------------------------------------
// mt19937_generator
// MT19937 32-bit generator with raw and Bernoulli draws over a stream port.
// ----------------------------------------------------------------------------
// Each draw passes S_RDB and S_CALC after accept; its result is registered once
//   the output is free, else held in S_OUT; no request is taken before that.
//   Each draw twists one word in place and needs two reads of the state
//   memory's single read port, then a write. The first draw after reset or a
//   seed write fills the store first in S_SEED, then issues a fresh read in S_RDA.
// Reset: seed back to 5489, store marked unseeded, output empty.
`default_nettype none

module mt19937_generator
    import mt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // seed register
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [32:0] probability, [39:33] zero
    input  wire logic        s_tuser,   // [0] mode
    // result channel
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic      [39:0] m_tdata    // [31:0] value, [32] hit, [39:33] zero
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              seeded_reg, seeded_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [WORD_W-1:0] nxt_reg, nxt_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              mode_reg, mode_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0] m_value_reg, m_value_next;
    logic              m_hit_reg, m_hit_next;

    logic              accept;
    logic              out_free;
    logic              fill_start;
    logic              fill_done;
    mt_wr_t            fill_wr;
    mt_wr_t            draw_wr;
    mt_wr_t            mem_wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [ADDR_W-1:0] idx_inc;
    logic [ADDR_W:0]   idx_m_sum;
    logic [ADDR_W-1:0] idx_m;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] temp_src;
    logic [WORD_W-1:0] tempered;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign fill_start = accept && !seeded_reg;

    // circular addresses k+1 and k+M
    assign idx_inc   = (idx_reg == LAST_ADDR) ? '0 : idx_reg + ADDR_W'(1);
    assign idx_m_sum = {1'b0, idx_reg} + {1'b0, OFFSET_M};
    assign idx_m     = (idx_m_sum >= N_WIDE) ? ADDR_W'(idx_m_sum - N_WIDE)
                                             : idx_m_sum[ADDR_W-1:0];

    // read address: k+1 outside S_RDB, k+M in S_RDB
    assign rd_addr = (state_reg == S_RDB) ? idx_m : idx_inc;

    // in-place twist of word k: entries below k already hold the new generation
    assign new_word = rd_data ^ mt_mix(cur_reg, nxt_reg);

    assign draw_wr.en   = (state_reg == S_CALC);
    assign draw_wr.addr = idx_reg;
    assign draw_wr.data = new_word;
    assign mem_wr       = (state_reg == S_CALC) ? draw_wr : fill_wr;

    assign temp_src = (state_reg == S_CALC) ? new_word : word_reg;
    assign tempered = mt_temper(temp_src);

    mt_ram u_ram (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mt_seed_fill u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fill_start),
        .seed    (seed_reg),
        .wr      (fill_wr),
        .done    (fill_done)
    );

    // draw sequencer
    always_comb begin
        state_next    = state_reg;
        seeded_next   = seeded_reg;
        seed_next     = seed_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        word_next     = word_reg;
        mode_next     = mode_reg;
        prob_next     = prob_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_hit_next    = m_hit_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cfg_wr_en) begin
                    seed_next   = cfg_wr_data;
                    seeded_next = 1'b0;
                    idx_next    = '0;
                end
                if (accept) begin
                    mode_next = s_tuser;
                    prob_next = s_tdata[PROB_W-1:0];
                    if (seeded_reg) begin
                        state_next = S_RDB;
                    end else begin
                        cur_next   = seed_reg;
                        idx_next   = '0;
                        state_next = S_SEED;
                    end
                end
            end
            S_SEED: begin
                if (fill_done) begin
                    seeded_next = 1'b1;
                    state_next  = S_RDA;
                end
            end
            S_RDA: begin
                state_next = S_RDB;
            end
            S_RDB: begin
                nxt_next   = rd_data;
                state_next = S_CALC;
            end
            S_CALC: begin
                word_next = new_word;
                cur_next  = nxt_reg;
                idx_next  = idx_inc;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = tempered;
                    m_hit_next    = mode_reg && ({1'b0, tempered} <= prob_reg);
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = tempered;
                    m_hit_next    = mode_reg && ({1'b0, tempered} <= prob_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            seeded_reg   <= 1'b0;
            seed_reg     <= SEED_RESET;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seeded_reg   <= seeded_next;
            seed_reg     <= seed_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        word_reg    <= word_next;
        mode_reg    <= mode_next;
        prob_reg    <= prob_next;
        m_value_reg <= m_value_next;
        m_hit_reg   <= m_hit_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_hit_reg, m_value_reg};

    // a seed write while idle clears the seeded flag, forcing a refill
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (state_reg == S_IDLE) |=> !seeded_reg)
        else $error("seed write did not clear seeded flag");

    // fill and draw never write the store in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fill_wr.en && (state_reg == S_CALC)))
        else $error("fill and draw write collide");

    // draws only run on a seeded store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDB) || (state_reg == S_CALC) |-> seeded_reg)
        else $error("draw on unseeded store");

    // word pointer stays inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_ADDR)
        else $error("word pointer out of range");

endmodule

`default_nettype wire

// ===== tb/mt19937_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_generator_tb
// Self-checking bench for the MT19937 generator. It sends raw and Bernoulli
// draw requests with random gaps and backpressure. It runs several seeds and
// tracks the full 624-word state in its own predictor, so the store wraps and
// twists a second time. Every result word and hit flag is checked in order.
// ----------------------------------------------------------------------------

module mt19937_generator_tb;
    import mt_pkg::*;

    typedef struct packed {
        logic        mode;
        logic [32:0] probability;
    } draw_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        hit;
    } draw_res_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;   // [32:0] probability, [39:33] zero
    logic        s_tuser     = 1'b0; // [0] mode
    logic        m_tready    = 1'b0;
    logic        m_tvalid;
    logic [39:0] m_tdata;            // [31:0] value, [32] hit, [39:33] zero

    mt19937_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    // predictor copy of the generator state
    logic [31:0] twist_store [MT_N];
    int unsigned next_word    = MT_N;
    bit          store_filled = 1'b0;
    logic [31:0] seed_value   = SEED_RESET;

    draw_req_t   pending_reqs[$];
    draw_res_t   expected_draws[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // next draw: seed fill and twist on demand, then temper
    function automatic draw_res_t predict_draw(input draw_req_t req);
        draw_res_t   res;
        logic [31:0] prev;
        logic [31:0] nxt;
        logic [31:0] y;
        if (!store_filled) begin
            twist_store[0] = seed_value;
            for (int i = 1; i < MT_N; i++) begin
                prev = twist_store[i - 1];
                twist_store[i] = MT_MULT * (prev ^ (prev >> 30)) + 32'(i);
            end
            store_filled = 1'b1;
            next_word    = MT_N;
        end
        if (next_word >= MT_N) begin
            for (int i = 0; i < MT_N; i++) begin
                nxt = twist_store[(i + 1) % MT_N];
                y   = {twist_store[i][31], nxt[30:0]};
                twist_store[i] = twist_store[(i + MT_M) % MT_N] ^ (y >> 1)
                                 ^ (nxt[0] ? MT_MATRIX : 32'h0);
            end
            next_word = 0;
        end
        y = twist_store[next_word];
        next_word++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        res.value = y;
        res.hit   = req.mode && ({1'b0, y} <= req.probability);
        return res;
    endfunction

    // request driver
    always @(posedge aclk) begin : drive_requests
        draw_req_t accepted;
        draw_req_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // request taken: predict its result now
            if (s_tvalid && s_tready) begin
                accepted.mode        = s_tuser;
                accepted.probability = s_tdata[32:0];
                expected_draws.push_back(predict_draw(accepted));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.mode;
                    s_tdata  <= {7'b0, next_req.probability};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and random backpressure
    always @(posedge aclk) begin : check_results
        draw_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing pending", m_tdata));
                end else begin
                    want = expected_draws.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch($sformatf("value %h, want %h",
                                                  m_tdata[31:0], want.value));
                    if (m_tdata[32] !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b (value %h)",
                                                  m_tdata[32], want.hit, want.value));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_request(input logic mode, input logic [32:0] probability);
        draw_req_t req;
        req.mode        = mode;
        req.probability = probability;
        pending_reqs.push_back(req);
    endtask

    // random draws: mostly plain fractions, some at or above one, some edges
    task automatic queue_random_draws(input int count);
        logic [32:0] prob;
        int unsigned sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                prob = {1'b0, 32'($urandom)};
            end else if (sel < 85) begin
                prob = {1'b1, 32'($urandom)};
            end else begin
                case ($urandom_range(4))
                    0:       prob = 33'h0_0000_0000;
                    1:       prob = 33'h0_0000_0001;
                    2:       prob = 33'h0_ffff_ffff;
                    3:       prob = 33'h1_0000_0000;
                    default: prob = 33'h1_ffff_ffff;
                endcase
            end
            queue_request(1'($urandom_range(1)), prob);
        end
    endtask

    // all requests sent and all results back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_draws.size() != 0);
    endtask

    // seed write, only while idle
    task automatic write_seed(input logic [31:0] seed);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= seed;
        seed_value   = seed;
        store_filled = 1'b0;
        next_word    = MT_N;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed draws on the reset seed
        send_idle_pct  = 14;
        recv_stall_pct = 46;
        queue_request(1'b0, 33'h0_0000_0000);
        queue_request(1'b0, 33'h1_ffff_ffff);   // raw mode keeps hit low
        queue_request(1'b0, 33'h1_0000_0000);
        queue_request(1'b1, 33'h0_0000_0000);
        queue_request(1'b1, 33'h0_0000_0001);
        queue_request(1'b1, 33'h0_7fff_ffff);
        queue_request(1'b1, 33'h0_8000_0000);
        queue_request(1'b1, 33'h0_ffff_fffe);
        queue_request(1'b1, 33'h0_ffff_ffff);
        queue_request(1'b1, 33'h1_0000_0000);   // probability of one saturates
        queue_request(1'b1, 33'h1_ffff_ffff);
        queue_request(1'b1, 33'h1_5555_5555);
        queue_request(1'b1, 33'h0_aaaa_aaaa);
        queue_request(1'b1, 33'h0_5555_5555);
        queue_request(1'b0, 33'h0_aaaa_aaaa);
        queue_request(1'b1, 33'h1_8000_0000);
        wait_drained();

        write_seed(32'h0000_0000);
        queue_random_draws(10);
        wait_drained();

        send_idle_pct  = 46;
        recv_stall_pct = 14;
        write_seed(32'($urandom));
        queue_random_draws(10);
        wait_drained();

        // long run past 624 words forces a second twist
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_seed(32'hffff_ffff);
        queue_random_draws(630);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
